FILE: design/dual_axis_autorange_normalizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-axis normalizer
// Shared property forms used by the checker of the normalizer unit.
// ----------------------------------------------------------------------------
`ifndef DUAL_AXIS_AUTORANGE_NORMALIZER_UNIT_MACROS_SVH
`define DUAL_AXIS_AUTORANGE_NORMALIZER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DANU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DANU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/danu_pkg.sv
// ----------------------------------------------------------------------------
// Dual-axis normalizer package
// Widths, reset constants, register indexes and the divider interface types.
// ----------------------------------------------------------------------------
package danu_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int LEVEL_W     = 7;
    localparam int QUO_W       = LEVEL_W;
    localparam int DEN_W       = SAMPLE_BITS;
    localparam int NUM_W       = SAMPLE_BITS + LEVEL_W;
    localparam int DSH_W       = DEN_W + QUO_W - 1;
    localparam int CNT_W       = $clog2(QUO_W + 1);
    localparam int XPROD_W     = 2 * LEVEL_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SAMPLE_BITS-1:0] RANGE_MIN_RESET = SAMPLE_BITS'(2400);
    localparam logic [SAMPLE_BITS-1:0] RANGE_MAX_RESET = SAMPLE_BITS'(2800);
    localparam logic [LEVEL_W-1:0]     LEVEL_FULL      = LEVEL_W'(100);
    localparam logic [LEVEL_W-1:0]     XTALK_RESET     = LEVEL_W'(10);
    localparam logic [LEVEL_W-1:0]     WARMUP_SAMPLES  = LEVEL_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_XTALK    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_XTALK = 1'b1;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

FILE: design/danu_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces a 7-bit quotient one bit per cycle. The caller guarantees that the
// quotient fits, that is num < 128 * den.
// ----------------------------------------------------------------------------
module danu_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  danu_pkg::t_div_req  i_req,
    output danu_pkg::t_div_rsp  o_rsp
);

    logic [danu_pkg::NUM_W-1:0] r_rem;
    logic [danu_pkg::DSH_W-1:0] r_dsh;
    logic [danu_pkg::QUO_W-1:0] r_quo;
    logic [danu_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic                       fits;

    assign fits = r_rem >= danu_pkg::NUM_W'(r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= danu_pkg::CNT_W'(danu_pkg::QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == danu_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dsh <= {i_req.den, {(danu_pkg::QUO_W-1){1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - danu_pkg::NUM_W'(r_dsh);
            end
            r_quo <= {r_quo[danu_pkg::QUO_W-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: design/dual_axis_autorange_normalizer_unit.sv
// ----------------------------------------------------------------------------
// Dual-axis auto-ranging normalizer
// Maps a throttle/brake ADC pair onto 0..100 levels with auto-ranging and
// crosstalk compensation, using one shared serial divider.
// ----------------------------------------------------------------------------
// The input channel takes one beat carrying a throttle and a brake sample.
// The output channel gives one beat with the compensated levels per input.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. Crosstalk percentages are written through the plain write
// port (index 0 brake, index 1 throttle); the user must write them only
// while the block is idle, which the block itself does not enforce. One
// item passes through a range update and four divisions on the shared
// divider: two range mappings and two crosstalk terms. A range mapping
// whose sample lies below its minimum or at or above its maximum skips the
// divider. The input stalls from acceptance until the result has entered
// the output register, so no new item is taken while one is in progress.
// The result sits in an output register, so a stalled receiver only
// holds up the block when a second result is ready before the first leaves.
// Reset restores the ranges to 2400..2800, restarts the 100-pair warm-up
// and sets both crosstalk percentages to 10.
// ----------------------------------------------------------------------------
module dual_axis_autorange_normalizer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [danu_pkg::SAMPLE_BITS-1:0]    i_throttle_sample,
    input  logic [danu_pkg::SAMPLE_BITS-1:0]    i_brake_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [danu_pkg::LEVEL_W-1:0]        o_throttle_level,
    output logic [danu_pkg::LEVEL_W-1:0]        o_brake_level,
    input  logic                                i_cfg_we,
    input  logic [danu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [danu_pkg::LEVEL_W-1:0]        i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WIDEN = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic [1:0]                          r_phase;
    logic [danu_pkg::SAMPLE_BITS-1:0]    r_thr_s;
    logic [danu_pkg::SAMPLE_BITS-1:0]    r_brk_s;
    logic [danu_pkg::LEVEL_W-1:0]        r_warm;
    logic [danu_pkg::SAMPLE_BITS-1:0]    r_thr_min;
    logic [danu_pkg::SAMPLE_BITS-1:0]    r_thr_max;
    logic [danu_pkg::SAMPLE_BITS-1:0]    r_brk_min;
    logic [danu_pkg::SAMPLE_BITS-1:0]    r_brk_max;
    logic [danu_pkg::LEVEL_W-1:0]        r_bpct;
    logic [danu_pkg::LEVEL_W-1:0]        r_tpct;
    logic [danu_pkg::LEVEL_W-1:0]        r_brk1;
    logic [danu_pkg::LEVEL_W-1:0]        r_thr1;
    logic [danu_pkg::LEVEL_W-1:0]        r_bx;
    logic [danu_pkg::LEVEL_W-1:0]        r_tx;
    logic                                r_out_valid;
    logic [danu_pkg::LEVEL_W-1:0]        r_thr_lvl;
    logic [danu_pkg::LEVEL_W-1:0]        r_brk_lvl;

    logic                                in_acc;
    logic                                out_free;
    logic [danu_pkg::SAMPLE_BITS-1:0]    sel_s;
    logic [danu_pkg::SAMPLE_BITS-1:0]    sel_lo;
    logic [danu_pkg::SAMPLE_BITS-1:0]    sel_hi;
    logic                                below;
    logic                                above;
    logic                                is_rng;
    logic                                direct;
    logic [danu_pkg::LEVEL_W-1:0]        direct_val;
    logic [danu_pkg::SAMPLE_BITS-1:0]    diff;
    logic [danu_pkg::SAMPLE_BITS-1:0]    span;
    logic [danu_pkg::NUM_W-1:0]          prod_rng;
    logic [danu_pkg::LEVEL_W-1:0]        xt_lvl;
    logic [danu_pkg::LEVEL_W-1:0]        xt_pct;
    logic [danu_pkg::XPROD_W-1:0]        prod_xt;
    logic                                store;
    logic [danu_pkg::LEVEL_W-1:0]        store_val;
    logic [danu_pkg::LEVEL_W-1:0]        brk2;
    logic [danu_pkg::LEVEL_W-1:0]        thr2;
    danu_pkg::t_div_req                  div_req;
    danu_pkg::t_div_rsp                  div_rsp;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign sel_s  = r_phase[0] ? r_thr_s   : r_brk_s;
    assign sel_lo = r_phase[0] ? r_thr_min : r_brk_min;
    assign sel_hi = r_phase[0] ? r_thr_max : r_brk_max;
    assign below  = sel_s < sel_lo;
    assign above  = sel_s >= sel_hi;
    assign diff   = sel_s - sel_lo;
    assign span   = sel_hi - sel_lo;
    assign prod_rng = danu_pkg::NUM_W'(diff) * danu_pkg::NUM_W'(danu_pkg::LEVEL_FULL);

    assign xt_lvl  = r_phase[0] ? r_brk1 : r_thr1;
    assign xt_pct  = r_phase[0] ? r_tpct : r_bpct;
    assign prod_xt = danu_pkg::XPROD_W'(xt_lvl) * danu_pkg::XPROD_W'(xt_pct);

    assign is_rng     = !r_phase[1];
    assign direct     = is_rng && (below || above);
    assign direct_val = below ? '0 : danu_pkg::LEVEL_FULL;

    assign div_req.start = (r_state == S_PREP) && !direct;
    assign div_req.num   = is_rng ? prod_rng : danu_pkg::NUM_W'(prod_xt);
    assign div_req.den   = is_rng ? span : danu_pkg::DEN_W'(danu_pkg::LEVEL_FULL);

    assign store     = ((r_state == S_PREP) && direct) || ((r_state == S_WAIT) && div_rsp.done);
    assign store_val = (r_state == S_PREP) ? direct_val : div_rsp.quo;

    assign brk2 = (r_brk1 > r_bx) ? r_brk1 - r_bx : '0;
    assign thr2 = (r_thr1 > r_tx) ? r_thr1 - r_tx : '0;

    danu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_WIDEN;
                end
            end
            S_WIDEN: begin
                n_state = S_PREP;
            end
            S_PREP, S_WAIT: begin
                if (store) begin
                    n_state = (r_phase == 2'd3) ? S_FIN : S_PREP;
                end else if (r_state == S_PREP) begin
                    n_state = S_WAIT;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_warm      <= '0;
            r_thr_min   <= danu_pkg::RANGE_MIN_RESET;
            r_thr_max   <= danu_pkg::RANGE_MAX_RESET;
            r_brk_min   <= danu_pkg::RANGE_MIN_RESET;
            r_brk_max   <= danu_pkg::RANGE_MAX_RESET;
            r_bpct      <= danu_pkg::XTALK_RESET;
            r_tpct      <= danu_pkg::XTALK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    danu_pkg::CFG_BRAKE_XTALK:    r_bpct <= i_cfg_data;
                    danu_pkg::CFG_THROTTLE_XTALK: r_tpct <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_WIDEN) begin
                r_phase <= '0;
                if (r_warm < danu_pkg::WARMUP_SAMPLES) begin
                    r_warm <= r_warm + 1'b1;
                end else begin
                    if (r_thr_s > r_thr_max) begin
                        r_thr_max <= r_thr_s;
                    end
                    if (r_thr_s < r_thr_min) begin
                        r_thr_min <= r_thr_s;
                    end
                    if (r_brk_s > r_brk_max) begin
                        r_brk_max <= r_brk_s;
                    end
                    if (r_brk_s < r_brk_min) begin
                        r_brk_min <= r_brk_s;
                    end
                end
            end
            if (store) begin
                r_phase <= r_phase + 1'b1;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_thr_s <= i_throttle_sample;
            r_brk_s <= i_brake_sample;
        end
        if (store) begin
            case (r_phase)
                2'd0:    r_brk1 <= store_val;
                2'd1:    r_thr1 <= store_val;
                2'd2:    r_bx   <= store_val;
                default: r_tx   <= store_val;
            endcase
        end
        if ((r_state == S_FIN) && out_free) begin
            r_thr_lvl <= thr2;
            r_brk_lvl <= brk2;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_throttle_level = r_thr_lvl;
    assign o_brake_level    = r_brk_lvl;

endmodule

FILE: design/danu_chk.sv
// ----------------------------------------------------------------------------
// Dual-axis normalizer port checker
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "dual_axis_autorange_normalizer_unit_macros.svh"

module danu_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [danu_pkg::LEVEL_W-1:0]        o_throttle_level,
    input logic [danu_pkg::LEVEL_W-1:0]        o_brake_level
);

    `DANU_ASSERT_SAME(a_level_range, o_out_valid, (o_throttle_level <= danu_pkg::LEVEL_FULL) && (o_brake_level <= danu_pkg::LEVEL_FULL), "Output level above full scale.")
    `DANU_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "Input not stalled after a beat was taken.")
    `DANU_ASSERT_SAME(a_result_while_busy, $rose(o_out_valid), $past(o_in_stall), "Result appeared without an item in progress.")
    `DANU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_throttle_level) && $stable(o_brake_level), "Stalled output beat changed.")

endmodule

bind dual_axis_autorange_normalizer_unit danu_chk u_danu_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_throttle_level (o_throttle_level),
    .o_brake_level    (o_brake_level)
);
